// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CAF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("complementary filter check failed");

// Checked on every edge, also while reset is high.
`define CAF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("complementary filter check failed");

`endif

// ----- rtl/caf_pkg.sv -----
// Shared constants, register indexes and the CORDIC angle table.
`default_nettype none
package caf_pkg;
  localparam int CORDIC_ITER_DEF = 16;
  localparam int CORDIC_ITER_MAX = 32;

  localparam logic [1:0] REG_BLEND_ALPHA = 2'd0;
  localparam logic [1:0] REG_GYRO_GAIN   = 2'd1;
  localparam logic [1:0] REG_MIN_NORM    = 2'd2;

  localparam logic [15:0] ALPHA_RESET = 16'd1311;
  localparam logic [31:0] GAIN_RESET  = 32'd262144;
  localparam logic [15:0] NORM_RESET  = 16'd410;

  // 180 degrees in Q16.16.
  localparam logic signed [31:0] HALF_TURN = 32'sd11796480;

  // atan(2^-i) in Q16.16 degrees, rounded to nearest.
  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd2949120;
      5'd1:  r = 32'sd1740967;
      5'd2:  r = 32'sd919879;
      5'd3:  r = 32'sd466945;
      5'd4:  r = 32'sd234379;
      5'd5:  r = 32'sd117304;
      5'd6:  r = 32'sd58666;
      5'd7:  r = 32'sd29335;
      5'd8:  r = 32'sd14668;
      5'd9:  r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/caf_if.sv -----
// Sample and result channel interfaces.
`default_nettype none
interface caf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_z;
  logic        [31:0] timestamp_ticks;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_z,
                  timestamp_ticks, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_z,
                timestamp_ticks, output ready);
endinterface

interface caf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pitch_deg;
  logic signed [31:0] yaw_deg;
  modport source (output valid, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

// ----- rtl/caf_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module caf_mul import caf_pkg::*; (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// ----- rtl/caf_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module caf_isqrt import caf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic [15:0]      root
);
  logic [31:0] rem;
  logic [31:0] acc;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {1'b0, acc} + {1'b0, bitv};
  assign root  = acc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        acc  <= '0;
        bitv <= 32'h4000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[31:0];
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/caf_cordic.sv -----
// Vectoring CORDIC, one rotation per cycle, giving atan2 in Q16.16 degrees.
`default_nettype none
module caf_cordic import caf_pkg::*; #(
  parameter int ITERATIONS = CORDIC_ITER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] x_in,
  input  wire logic signed [16:0] y_in,
  output logic                    done,
  output logic signed [31:0]      angle
);
  logic signed [37:0] x;
  logic signed [37:0] y;
  logic signed [31:0] z;
  logic [5:0]         cnt;
  logic               busy;
  logic signed [37:0] xs;
  logic signed [37:0] ys;
  logic signed [37:0] dx;
  logic signed [37:0] dy;

  assign xs    = 38'(x_in) <<< 16;
  assign ys    = 38'(y_in) <<< 16;
  assign dx    = y >>> cnt[4:0];
  assign dy    = x >>> cnt[4:0];
  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (x_in == 17'sd0 && y_in == 17'sd0) begin
          z    <= '0;
          done <= 1'b1;
        end else if (x_in < 0) begin
          // Left half plane: fold over by a half turn first.
          z    <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
          x    <= -xs;
          y    <= -ys;
          busy <= 1'b1;
        end else begin
          z    <= '0;
          x    <= xs;
          y    <= ys;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_deg(cnt[4:0]);
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_deg(cnt[4:0]);
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/complementary_attitude_filter_core.sv -----
// Top level: sequencer of the complementary attitude filter.
//
// Samples enter on the sample channel and pitch/yaw leave on the result
// channel; an item moves when valid and ready are both high. Registers are
// written through cfg_we/cfg_index/cfg_data (0 blend alpha, 1 gyro gain,
// 2 minimum accel norm); other indexes are ignored.
// One sample is worked on at a time and sample.ready is high only while the
// sequencer is idle. The first sample after reset (stored timestamp zero)
// is only stored and gives no item. A sample with weak acceleration skips
// the square root, CORDIC and gyro steps and gives the held angles; a full
// update runs the 16-step square root and the two passes through the
// shared CORDIC unit, then the gyro and blend steps for each axis.
// One multiplier serves the squares and both gyro and blend products.
// Reset clears the angles and stored timestamp and restores register
// defaults. A stalled receiver holds the result register; the sequencer
// waits at its end until that register is free.
`default_nettype none
module complementary_attitude_filter_core import caf_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  caf_sample_if.sink       sample,
  caf_result_if.source     result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAX  = 4'd1;
  localparam logic [3:0] S_MAY  = 4'd2;
  localparam logic [3:0] S_MAZ  = 4'd3;
  localparam logic [3:0] S_MTH  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_CP   = 4'd7;
  localparam logic [3:0] S_CY   = 4'd8;
  localparam logic [3:0] S_G1   = 4'd9;
  localparam logic [3:0] S_G2   = 4'd10;
  localparam logic [3:0] S_G3   = 4'd11;
  localparam logic [3:0] S_G4   = 4'd12;
  localparam logic [3:0] S_G5   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]         state;
  logic [15:0]        blend_alpha;
  logic [31:0]        gyro_gain;
  logic [15:0]        min_accel_norm;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  logic [31:0]        last_timestamp;
  logic signed [15:0] ax, ay, az, gx, gz;
  logic [15:0]        dt;
  logic [32:0]        norm;
  logic [31:0]        hsq;
  logic signed [31:0] acc_pitch;
  logic signed [31:0] acc_yaw;
  logic signed [31:0] pred;
  logic               axis;
  logic               ovalid;
  logic signed [31:0] opitch;
  logic signed [31:0] oyaw;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic               sq_start, sq_done;
  logic [15:0]        sq_root;
  logic               cd_start, cd_done;
  logic signed [16:0] cd_x, cd_y;
  logic signed [31:0] cd_angle;
  logic [31:0]        diff;
  logic signed [31:0] cur_angle;
  logic signed [31:0] cur_accel;
  logic signed [15:0] cur_gyro;
  logic               load_out;

  assign sample.ready   = (state == S_IDLE);
  assign result.valid   = ovalid;
  assign result.pitch_deg = opitch;
  assign result.yaw_deg   = oyaw;

  assign diff      = sample.timestamp_ticks - last_timestamp;
  assign cur_angle = axis ? yaw_angle : pitch_angle;
  assign cur_accel = axis ? acc_yaw : acc_pitch;
  assign cur_gyro  = axis ? gz : gx;
  assign load_out  = (state == S_OUT) && (!ovalid || result.ready);

  assign sq_start = (state == S_CMP) && (norm > prod[32:0]);
  assign cd_start = ((state == S_SQRT) && sq_done) || ((state == S_CP) && cd_done);
  assign cd_x = (state == S_SQRT) ? $signed({1'b0, sq_root}) : -17'(ay);
  assign cd_y = (state == S_SQRT) ? -17'(az) : 17'(ax);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_MAX: begin
        ma = 33'(ax);
        mb = 33'(ax);
      end
      S_MAY: begin
        ma = 33'(ay);
        mb = 33'(ay);
      end
      S_MAZ: begin
        ma = 33'(az);
        mb = 33'(az);
      end
      S_MTH: begin
        ma = $signed({17'b0, min_accel_norm});
        mb = $signed({17'b0, min_accel_norm});
      end
      S_G1: begin
        ma = 33'(cur_gyro);
        mb = $signed({17'b0, dt});
      end
      S_G2: begin
        ma = prod[32:0];
        mb = $signed({1'b0, gyro_gain});
      end
      S_G4: begin
        // Blend as pred + alpha * (accel - pred), one product.
        ma = 33'(cur_accel) - 33'(pred);
        mb = $signed({17'b0, blend_alpha});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  caf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  caf_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(hsq),
    .done(sq_done), .root(sq_root)
  );

  caf_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(cd_start), .x_in(cd_x), .y_in(cd_y),
    .done(cd_done), .angle(cd_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      blend_alpha    <= ALPHA_RESET;
      gyro_gain      <= GAIN_RESET;
      min_accel_norm <= NORM_RESET;
      pitch_angle    <= '0;
      yaw_angle      <= '0;
      last_timestamp <= '0;
      axis           <= 1'b0;
      ovalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLEND_ALPHA: blend_alpha    <= cfg_data[15:0];
          REG_GYRO_GAIN:   gyro_gain      <= cfg_data;
          REG_MIN_NORM:    min_accel_norm <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (load_out) begin
        ovalid <= 1'b1;
        opitch <= pitch_angle;
        oyaw   <= yaw_angle;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ax <= sample.accel_x;
            ay <= sample.accel_y;
            az <= sample.accel_z;
            gx <= sample.gyro_x;
            gz <= sample.gyro_z;
            last_timestamp <= sample.timestamp_ticks;
            dt <= (diff > 32'd65535) ? 16'hFFFF : diff[15:0];
            if (last_timestamp != 32'd0) state <= S_MAX;
          end
        end
        S_MAX: state <= S_MAY;
        S_MAY: begin
          norm  <= prod[32:0];
          state <= S_MAZ;
        end
        S_MAZ: begin
          hsq   <= norm[31:0] + prod[31:0];
          norm  <= norm + prod[32:0];
          state <= S_MTH;
        end
        S_MTH: begin
          norm  <= norm + prod[32:0];
          state <= S_CMP;
        end
        S_CMP: state <= sq_start ? S_SQRT : S_OUT;
        S_SQRT: if (sq_done) state <= S_CP;
        S_CP: begin
          if (cd_done) begin
            acc_pitch <= cd_angle;
            state     <= S_CY;
          end
        end
        S_CY: begin
          if (cd_done) begin
            acc_yaw <= cd_angle;
            axis    <= 1'b0;
            state   <= S_G1;
          end
        end
        S_G1: state <= S_G2;
        S_G2: state <= S_G3;
        S_G3: begin
          pred  <= cur_angle - prod[47:16];
          state <= S_G4;
        end
        S_G4: state <= S_G5;
        S_G5: begin
          if (axis) begin
            yaw_angle <= pred + prod[47:16];
            state     <= S_OUT;
          end else begin
            pitch_angle <= pred + prod[47:16];
            axis        <= 1'b1;
            state       <= S_G1;
          end
        end
        S_OUT: if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/caf_checker.sv -----
// Port-level checks of the filter core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module caf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pitch,
  input wire logic [31:0] out_yaw
);
  logic [63:0] out_payload;

  assign out_payload = {out_pitch, out_yaw};

  `CAF_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid)
  `CAF_ASSERT(a_no_early_result, clk, rst, in_valid && in_ready |=> !$rose(out_valid))
  `CAF_ASSERT(a_result_from_busy, clk, rst, $rose(out_valid) |-> !$past(in_ready))
  `CAF_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_payload))
endmodule

bind complementary_attitude_filter_core caf_checker u_caf_checker (
  .clk(clk), .rst(rst),
  .in_valid(sample.valid), .in_ready(sample.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .out_pitch(result.pitch_deg), .out_yaw(result.yaw_deg)
);
`default_nettype wire
